// ===== design/qwm_pkg.sv =====
// shared types, constants and helpers for the quadrotor motor mixer
package qwm_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int GAIN_W = 32;
	localparam int WRENCH_W = 32;
	localparam int PROD_W = 64;
	localparam int SUM_W = 66;
	localparam int SPEED_W = 16;
	localparam int SQ_W = 32;
	localparam int CMD_W = 15;
	localparam int SCALE_FRAC = 16;
	localparam int SQRT_STAGES = 8;
	localparam logic [CMD_W-1:0] CMD_MAX = 15'h7FFF;

	// bit m set: that term enters motor m negated
	localparam logic [NUM_MOTORS-1:0] ROLL_NEG = 4'b0110;
	localparam logic [NUM_MOTORS-1:0] PITCH_NEG = 4'b0011;
	localparam logic [NUM_MOTORS-1:0] YAW_NEG = 4'b0101;

	typedef enum logic [2:0] {
		REG_THRUST_GAIN = 3'd0,
		REG_ROLL_PITCH_GAIN = 3'd1,
		REG_YAW_GAIN = 3'd2,
		REG_MIN_SPEED = 3'd3,
		REG_MAX_SPEED = 3'd4,
		REG_COMMAND_SCALE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] root;
		logic [SQ_W-1:0] root_sq;
	} sqrt_t;

	// one digit of the square root; root_sq tracks root squared
	function automatic sqrt_t sqrt_step(input logic [SQ_W-1:0] v, input sqrt_t cur,
			input int k);
		logic [SQ_W+1:0] trial;
		sqrt_t nxt;
		trial = (SQ_W+2)'(cur.root_sq) + ((SQ_W+2)'(cur.root) << (k + 1))
			+ ((SQ_W+2)'(1) << (2 * k));
		nxt = cur;
		if (trial <= (SQ_W+2)'(v)) begin
			nxt.root = cur.root | (SPEED_W'(1) << k);
			nxt.root_sq = trial[SQ_W-1:0];
		end
		return nxt;
	endfunction

	typedef struct packed {
		logic en;
	} pipe_ctl_t;

endpackage

// ===== design/qwm_if.sv =====
// handshake channels for wrench words and motor command words
interface qwm_wrench_if;
	logic valid;
	logic ready;
	logic signed [31:0] force_z;
	logic signed [31:0] torque_x;
	logic signed [31:0] torque_y;
	logic signed [31:0] torque_z;
	modport source(output valid, force_z, torque_x, torque_y, torque_z, input ready);
	modport sink(input valid, force_z, torque_x, torque_y, torque_z, output ready);
endinterface

interface qwm_command_if;
	logic valid;
	logic ready;
	logic [14:0] motor0_command;
	logic [14:0] motor1_command;
	logic [14:0] motor2_command;
	logic [14:0] motor3_command;
	modport source(output valid, motor0_command, motor1_command, motor2_command,
		motor3_command, input ready);
	modport sink(input valid, motor0_command, motor1_command, motor2_command,
		motor3_command, output ready);
endinterface

// ===== design/qwm_mix.sv =====
// gain products, signed mixing, fraction shift and squared speed clamp
module qwm_mix #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input qwm_pkg::pipe_ctl_t ctl,
	input logic in_valid,
	input logic signed [qwm_pkg::WRENCH_W-1:0] force_z,
	input logic signed [qwm_pkg::WRENCH_W-1:0] torque_x,
	input logic signed [qwm_pkg::WRENCH_W-1:0] torque_y,
	input logic signed [qwm_pkg::WRENCH_W-1:0] torque_z,
	input logic [qwm_pkg::GAIN_W-1:0] thrust_gain,
	input logic [qwm_pkg::GAIN_W-1:0] roll_pitch_gain,
	input logic [qwm_pkg::GAIN_W-1:0] yaw_gain,
	input logic [qwm_pkg::SQ_W-1:0] min_sq,
	input logic [qwm_pkg::SQ_W-1:0] max_sq,
	output logic out_valid,
	output logic [qwm_pkg::SQ_W-1:0] sq [qwm_pkg::NUM_MOTORS]
);
	localparam int PW = qwm_pkg::PROD_W;
	localparam int SW = qwm_pkg::SUM_W;
	localparam int NM = qwm_pkg::NUM_MOTORS;

	logic [5:1] valid_q;
	logic signed [PW:0] pf_w, px_w, py_w, pz_w;
	logic signed [PW-1:0] pf_s1, px_s1, py_s1, pz_s1;
	logic signed [PW:0] a_s2 [NM];
	logic signed [PW:0] b_s2 [NM];
	logic signed [SW-1:0] sq_s3 [NM];
	logic signed [SW-1:0] sq_s4 [NM];
	logic [qwm_pkg::SQ_W-1:0] sq_s5 [NM];

	assign pf_w = $signed({1'b0, thrust_gain}) * force_z;
	assign px_w = $signed({1'b0, roll_pitch_gain}) * torque_x;
	assign py_w = $signed({1'b0, roll_pitch_gain}) * torque_y;
	assign pz_w = $signed({1'b0, yaw_gain}) * torque_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.en) begin
			valid_q <= {valid_q[4:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			pf_s1 <= pf_w[PW-1:0];
			px_s1 <= px_w[PW-1:0];
			py_s1 <= py_w[PW-1:0];
			pz_s1 <= pz_w[PW-1:0];
		end
	end

	for (genvar m = 0; m < NM; m++) begin : g_motor
		logic signed [PW:0] fe, xe, ye, ze;
		logic signed [SW-1:0] sum_w;
		assign fe = {pf_s1[PW-1], pf_s1};
		assign xe = {px_s1[PW-1], px_s1};
		assign ye = {py_s1[PW-1], py_s1};
		assign ze = {pz_s1[PW-1], pz_s1};
		assign sum_w = {a_s2[m][PW], a_s2[m]} + {b_s2[m][PW], b_s2[m]};

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				a_s2[m] <= qwm_pkg::ROLL_NEG[m] ? fe - xe : fe + xe;
				b_s2[m] <= (qwm_pkg::PITCH_NEG[m] ? -ye : ye)
					+ (qwm_pkg::YAW_NEG[m] ? -ze : ze);
				sq_s3[m] <= sum_w >>> FRAC_BITS;
				// lower clamp first, upper clamp wins
				sq_s4[m] <= (sq_s3[m] < $signed({{(SW-qwm_pkg::SQ_W){1'b0}}, min_sq}))
					? $signed({{(SW-qwm_pkg::SQ_W){1'b0}}, min_sq}) : sq_s3[m];
				sq_s5[m] <= (sq_s4[m] > $signed({{(SW-qwm_pkg::SQ_W){1'b0}}, max_sq}))
					? max_sq : sq_s4[m][qwm_pkg::SQ_W-1:0];
			end
		end
	end

	assign out_valid = valid_q[5];
	assign sq = sq_s5;
endmodule

// ===== design/qwm_sqrt.sv =====
// pipelined floor square root, two digits per stage, four lanes
module qwm_sqrt (
	input logic clk,
	input logic arst_n,
	input qwm_pkg::pipe_ctl_t ctl,
	input logic in_valid,
	input logic [qwm_pkg::SQ_W-1:0] sq [qwm_pkg::NUM_MOTORS],
	output logic out_valid,
	output logic [qwm_pkg::SPEED_W-1:0] speed [qwm_pkg::NUM_MOTORS]
);
	localparam int NS = qwm_pkg::SQRT_STAGES;
	localparam int NM = qwm_pkg::NUM_MOTORS;

	logic [NS-1:0] valid_q;
	logic [qwm_pkg::SQ_W-1:0] v_s [NS][NM];
	qwm_pkg::sqrt_t r_s [NS][NM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.en) begin
			valid_q <= {valid_q[NS-2:0], in_valid};
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_stage
		for (genvar m = 0; m < NM; m++) begin : g_lane
			logic [qwm_pkg::SQ_W-1:0] v_in;
			qwm_pkg::sqrt_t r_in, r_mid, r_out;
			if (g == 0) begin : g_first
				assign v_in = sq[m];
				assign r_in = '0;
			end else begin : g_next
				assign v_in = v_s[g-1][m];
				assign r_in = r_s[g-1][m];
			end
			assign r_mid = qwm_pkg::sqrt_step(v_in, r_in, 15 - 2 * g);
			assign r_out = qwm_pkg::sqrt_step(v_in, r_mid, 14 - 2 * g);
			always_ff @(posedge clk) begin
				if (ctl.en) begin
					v_s[g][m] <= v_in;
					r_s[g][m] <= r_out;
				end
			end
		end
	end

	for (genvar m = 0; m < NM; m++) begin : g_out
		assign speed[m] = r_s[NS-1][m].root;
	end
	assign out_valid = valid_q[NS-1];
endmodule

// ===== design/qwm_scale.sv =====
// command scaling with saturation, last stage is the output register
module qwm_scale (
	input logic clk,
	input logic arst_n,
	input qwm_pkg::pipe_ctl_t ctl,
	input logic in_valid,
	input logic [qwm_pkg::SPEED_W-1:0] speed [qwm_pkg::NUM_MOTORS],
	input logic [qwm_pkg::GAIN_W-1:0] command_scale,
	output logic out_valid,
	output logic [qwm_pkg::CMD_W-1:0] cmd [qwm_pkg::NUM_MOTORS]
);
	localparam int PW = qwm_pkg::GAIN_W + qwm_pkg::SPEED_W;
	localparam int NM = qwm_pkg::NUM_MOTORS;

	logic [2:1] valid_q;
	logic [PW-1:0] prod_s1 [NM];
	logic [qwm_pkg::CMD_W-1:0] cmd_s2 [NM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.en) begin
			valid_q <= {valid_q[1], in_valid};
		end
	end

	for (genvar m = 0; m < NM; m++) begin : g_lane
		logic [PW-qwm_pkg::SCALE_FRAC-1:0] whole;
		assign whole = prod_s1[m][PW-1:qwm_pkg::SCALE_FRAC];
		always_ff @(posedge clk) begin
			if (ctl.en) begin
				prod_s1[m] <= PW'(command_scale) * PW'(speed[m]);
				cmd_s2[m] <= (whole > (PW-qwm_pkg::SCALE_FRAC)'(qwm_pkg::CMD_MAX))
					? qwm_pkg::CMD_MAX : whole[qwm_pkg::CMD_W-1:0];
			end
		end
	end

	assign out_valid = valid_q[2];
	assign cmd = cmd_s2;
endmodule

// ===== design/quadrotor_wrench_to_motor_command_core.sv =====
// Quadrotor X motor mixer: wrench words in, four motor command words out.
// Channel wrench carries thrust and roll, pitch and yaw torques in signed
// fixed point with FRAC_BITS fraction bits; channel command returns four
// 15-bit motor commands, one command word for each wrench word.
// Gains, speed limits and the command scale sit on a plain write port
// (cfg_we, cfg_index, cfg_data); write them only while the block is idle.
// Words pass through products, mixing and clamping, then the square root
// (two root digits per stage), then scaling and saturation.
// One word per cycle unless the receiver stalls; all stages advance together.
// When the receiver stalls with a word waiting, every stage holds and
// wrench.ready drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module quadrotor_wrench_to_motor_command_core #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	qwm_wrench_if.sink wrench,
	qwm_command_if.source command
);
	localparam int NM = qwm_pkg::NUM_MOTORS;

	logic [qwm_pkg::GAIN_W-1:0] thrust_gain_q, roll_pitch_gain_q, yaw_gain_q;
	logic [qwm_pkg::GAIN_W-1:0] command_scale_q;
	logic [qwm_pkg::SPEED_W-1:0] min_speed_q, max_speed_q;
	logic [qwm_pkg::SQ_W-1:0] min_sq_q, max_sq_q;
	qwm_pkg::pipe_ctl_t ctl;
	logic mix_valid, sqrt_valid, out_valid;
	logic [qwm_pkg::SQ_W-1:0] sq [NM];
	logic [qwm_pkg::SPEED_W-1:0] speed [NM];
	logic [qwm_pkg::CMD_W-1:0] cmd [NM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_gain_q <= 32'd1689189;
			roll_pitch_gain_q <= 32'd9936407;
			yaw_gain_q <= 32'd125000000;
			min_speed_q <= 16'd0;
			max_speed_q <= 16'd10000;
			command_scale_q <= 32'd214741;
		end else if (cfg_we) begin
			case (cfg_index)
				qwm_pkg::REG_THRUST_GAIN: thrust_gain_q <= cfg_data;
				qwm_pkg::REG_ROLL_PITCH_GAIN: roll_pitch_gain_q <= cfg_data;
				qwm_pkg::REG_YAW_GAIN: yaw_gain_q <= cfg_data;
				qwm_pkg::REG_MIN_SPEED: min_speed_q <= cfg_data[15:0];
				qwm_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data[15:0];
				qwm_pkg::REG_COMMAND_SCALE: command_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// squared limits, settled long before a word reaches the clamp
	always_ff @(posedge clk) begin
		min_sq_q <= qwm_pkg::SQ_W'(min_speed_q) * qwm_pkg::SQ_W'(min_speed_q);
		max_sq_q <= qwm_pkg::SQ_W'(max_speed_q) * qwm_pkg::SQ_W'(max_speed_q);
	end

	assign ctl.en = !out_valid || command.ready;
	assign wrench.ready = ctl.en;

	qwm_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_valid(wrench.valid),
		.force_z(wrench.force_z), .torque_x(wrench.torque_x),
		.torque_y(wrench.torque_y), .torque_z(wrench.torque_z),
		.thrust_gain(thrust_gain_q), .roll_pitch_gain(roll_pitch_gain_q),
		.yaw_gain(yaw_gain_q), .min_sq(min_sq_q), .max_sq(max_sq_q),
		.out_valid(mix_valid), .sq(sq)
	);

	qwm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_valid(mix_valid), .sq(sq),
		.out_valid(sqrt_valid), .speed(speed)
	);

	qwm_scale u_scale (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_valid(sqrt_valid), .speed(speed), .command_scale(command_scale_q),
		.out_valid(out_valid), .cmd(cmd)
	);

	assign command.valid = out_valid;
	assign command.motor0_command = cmd[0];
	assign command.motor1_command = cmd[1];
	assign command.motor2_command = cmd[2];
	assign command.motor3_command = cmd[3];
endmodule

// ===== test/qwm_checker.sv =====
// checker: predicts motor command words from wrench words and compares them
module qwm_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	qwm_wrench_if wrench,
	qwm_command_if command,
	output int fail_count,
	output int pending,
	output int words_in,
	output int words_out
);
	typedef struct packed {
		logic [14:0] m0;
		logic [14:0] m1;
		logic [14:0] m2;
		logic [14:0] m3;
	} cmd_word_t;

	logic [31:0] thrust_gain, roll_pitch_gain, yaw_gain, command_scale;
	logic [15:0] min_speed, max_speed;
	cmd_word_t expected_cmds[$];

	function automatic logic [15:0] floor_root(input logic [31:0] v);
		logic [15:0] r;
		logic [15:0] t;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (16'd1 << b);
			if ({32'd0, t} * {32'd0, t} <= {32'd0, v})
				r = t;
		end
		return r;
	endfunction

	// exact mix: 70-bit signed sum, arithmetic shift floors
	function automatic logic [14:0] motor_cmd(input logic signed [31:0] f,
			input logic signed [31:0] tx, input logic signed [31:0] ty,
			input logic signed [31:0] tz, input bit nr, input bit np, input bit ny);
		logic signed [69:0] acc;
		logic signed [69:0] sq;
		logic signed [69:0] lo_sq;
		logic signed [69:0] hi_sq;
		logic [15:0] spd;
		logic [63:0] cmd;
		acc = $signed({38'd0, thrust_gain}) * 70'(f);
		acc = nr ? acc - $signed({38'd0, roll_pitch_gain}) * 70'(tx)
			: acc + $signed({38'd0, roll_pitch_gain}) * 70'(tx);
		acc = np ? acc - $signed({38'd0, roll_pitch_gain}) * 70'(ty)
			: acc + $signed({38'd0, roll_pitch_gain}) * 70'(ty);
		acc = ny ? acc - $signed({38'd0, yaw_gain}) * 70'(tz)
			: acc + $signed({38'd0, yaw_gain}) * 70'(tz);
		sq = acc >>> 16;
		lo_sq = $signed({38'd0, 32'(min_speed) * 32'(min_speed)});
		hi_sq = $signed({38'd0, 32'(max_speed) * 32'(max_speed)});
		if (sq < lo_sq)
			sq = lo_sq;
		if (sq > hi_sq)
			sq = hi_sq;
		spd = floor_root(sq[31:0]);
		if (spd > max_speed)
			spd = max_speed;
		cmd = (64'(command_scale) * 64'(spd)) >> qwm_pkg::SCALE_FRAC;
		if (cmd > 64'(qwm_pkg::CMD_MAX))
			cmd = 64'(qwm_pkg::CMD_MAX);
		return cmd[14:0];
	endfunction

	assign pending = expected_cmds.size();

	always @(posedge clk or negedge arst_n) begin
		cmd_word_t exp_w;
		cmd_word_t got;
		if (!arst_n) begin
			thrust_gain <= 32'd1689189;
			roll_pitch_gain <= 32'd9936407;
			yaw_gain <= 32'd125000000;
			min_speed <= 16'd0;
			max_speed <= 16'd10000;
			command_scale <= 32'd214741;
			fail_count <= 0;
			words_in <= 0;
			words_out <= 0;
			expected_cmds.delete();
		end else begin
			if (wrench.valid && wrench.ready) begin
				exp_w.m0 = motor_cmd(wrench.force_z, wrench.torque_x, wrench.torque_y,
					wrench.torque_z, 0, 1, 1);
				exp_w.m1 = motor_cmd(wrench.force_z, wrench.torque_x, wrench.torque_y,
					wrench.torque_z, 1, 1, 0);
				exp_w.m2 = motor_cmd(wrench.force_z, wrench.torque_x, wrench.torque_y,
					wrench.torque_z, 1, 0, 1);
				exp_w.m3 = motor_cmd(wrench.force_z, wrench.torque_x, wrench.torque_y,
					wrench.torque_z, 0, 0, 0);
				expected_cmds.push_back(exp_w);
				words_in <= words_in + 1;
			end
			if (command.valid && command.ready) begin
				got = {command.motor0_command, command.motor1_command,
					command.motor2_command, command.motor3_command};
				words_out <= words_out + 1;
				if (expected_cmds.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected command word %h", got);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_cmds.pop_front();
					if (got !== exp_w) begin
						if (fail_count < 10)
							$display("command mismatch: expected %h %h %h %h got %h %h %h %h",
								exp_w.m0, exp_w.m1, exp_w.m2, exp_w.m3,
								got.m0, got.m1, got.m2, got.m3);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					qwm_pkg::REG_THRUST_GAIN: thrust_gain <= cfg_data;
					qwm_pkg::REG_ROLL_PITCH_GAIN: roll_pitch_gain <= cfg_data;
					qwm_pkg::REG_YAW_GAIN: yaw_gain <= cfg_data;
					qwm_pkg::REG_MIN_SPEED: min_speed <= cfg_data[15:0];
					qwm_pkg::REG_MAX_SPEED: max_speed <= cfg_data[15:0];
					qwm_pkg::REG_COMMAND_SCALE: command_scale <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== test/testbench.sv =====
// testbench top: drives wrench words and register writes, gives the verdict
module testbench;
	localparam int LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int fail_count, pending, words_in, words_out;
	int idle_cycles = 0;
	int stall_mode = 0;
	bit timed_out = 0;

	qwm_wrench_if wrench();
	qwm_command_if command();

	quadrotor_wrench_to_motor_command_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .wrench(wrench), .command(command)
	);

	qwm_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .wrench(wrench), .command(command),
		.fail_count(fail_count), .pending(pending), .words_in(words_in),
		.words_out(words_out)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// receiver stall pattern changes mode now and then
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: command.ready <= 1'b1;
			1: command.ready <= ($urandom_range(0, 3) != 0);
			2: command.ready <= ($urandom_range(0, 3) == 0);
			default: command.ready <= ($urandom_range(0, 19) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((wrench.valid && wrench.ready) || (command.valid && command.ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired");
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'($urandom_range(0, 1 << 20));
			5: return -32'($urandom_range(0, 1 << 20));
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input qwm_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic write_bad_index();
		cfg_we = 1;
		cfg_index = 3'd6 + 3'($urandom_range(0, 1));
		cfg_data = $urandom;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// one wrench word, held until accepted; bursty gaps before it
	task automatic send_wrench(input logic [31:0] f, input logic [31:0] tx,
			input logic [31:0] ty, input logic [31:0] tz, input bit gap);
		if (gap)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		wrench.valid = 1;
		wrench.force_z = f;
		wrench.torque_x = tx;
		wrench.torque_y = ty;
		wrench.torque_z = tz;
		@(posedge clk);
		while (!wrench.ready)
			@(posedge clk);
		@(negedge clk);
		wrench.valid = 0;
	endtask

	task automatic send_burst(input int count, input int kind);
		logic [31:0] f, tx, ty, tz;
		bit gap;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			gap = 0;
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = $urandom_range(0, 1);
			end
			burst--;
			if (kind == 0) begin
				f = $urandom;
				tx = $urandom;
				ty = $urandom;
				tz = $urandom;
			end else if (kind == 1) begin
				f = edge_value();
				tx = edge_value();
				ty = edge_value();
				tz = edge_value();
			end else begin
				// hover-like inputs: modest thrust, small signed torques
				f = $urandom_range(0, 32'h0040_0000);
				tx = 32'($signed(32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000));
				ty = 32'($signed(32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000));
				tz = 32'($signed(32'($urandom_range(0, 32'h0000_2000)) - 32'h0000_1000));
			end
			send_wrench(f, tx, ty, tz, gap);
		end
	endtask

	initial begin
		wrench.valid = 0;
		wrench.force_z = 0;
		wrench.torque_x = 0;
		wrench.torque_y = 0;
		wrench.torque_z = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed words at reset settings
		send_wrench(32'h0, 32'h0, 32'h0, 32'h0, 0);
		send_wrench(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 0);
		send_wrench(32'h8000_0000, 32'h0, 32'h0, 32'h0, 0);
		send_wrench(32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_wrench(32'h0010_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_wrench(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_wrench(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_wrench(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_wrench(32'h0001_0000, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_0100, 0);
		send_wrench(32'h0030_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0800, 0);
		drain();

		// all gains at max, scale at max: saturation and wide sums
		write_reg(qwm_pkg::REG_THRUST_GAIN, 32'hFFFF_FFFF);
		write_reg(qwm_pkg::REG_ROLL_PITCH_GAIN, 32'hFFFF_FFFF);
		write_reg(qwm_pkg::REG_YAW_GAIN, 32'hFFFF_FFFF);
		write_reg(qwm_pkg::REG_MAX_SPEED, 32'hFFFF);
		write_reg(qwm_pkg::REG_COMMAND_SCALE, 32'hFFFF_FFFF);
		send_wrench(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
		send_wrench(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_wrench(32'h0000_0001, 32'h0, 32'h0, 32'h0, 0);
		drain();

		// min above max and a write to an unused index, then zero max, then zero scale
		write_reg(qwm_pkg::REG_MIN_SPEED, 32'd500);
		write_reg(qwm_pkg::REG_MAX_SPEED, 32'd100);
		write_bad_index();
		send_wrench(32'h0, 32'h0, 32'h0, 32'h0, 0);
		send_wrench(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 0);
		drain();
		write_reg(qwm_pkg::REG_MAX_SPEED, 32'd0);
		write_reg(qwm_pkg::REG_MIN_SPEED, 32'hFFFF);
		send_wrench(32'h0010_0000, 32'h0, 32'h0, 32'h0, 0);
		drain();
		write_reg(qwm_pkg::REG_COMMAND_SCALE, 32'd0);
		send_wrench(32'h0010_0000, 32'h0, 32'h0, 32'h0, 0);
		drain();

		// random phases through several settings
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin
					write_reg(qwm_pkg::REG_THRUST_GAIN, 32'd1689189);
					write_reg(qwm_pkg::REG_ROLL_PITCH_GAIN, 32'd9936407);
					write_reg(qwm_pkg::REG_YAW_GAIN, 32'd125000000);
					write_reg(qwm_pkg::REG_MIN_SPEED, 32'd0);
					write_reg(qwm_pkg::REG_MAX_SPEED, 32'd10000);
					write_reg(qwm_pkg::REG_COMMAND_SCALE, 32'd214741);
				end
				1: begin
					write_reg(qwm_pkg::REG_MIN_SPEED, 32'd1);
					write_reg(qwm_pkg::REG_MAX_SPEED, 32'd1);
				end
				2: begin
					write_reg(qwm_pkg::REG_THRUST_GAIN, 32'd0);
					write_reg(qwm_pkg::REG_ROLL_PITCH_GAIN, 32'd0);
					write_reg(qwm_pkg::REG_YAW_GAIN, 32'd0);
					write_reg(qwm_pkg::REG_MIN_SPEED, 32'hFFFF);
					write_reg(qwm_pkg::REG_MAX_SPEED, 32'hFFFF);
					write_reg(qwm_pkg::REG_COMMAND_SCALE, 32'h0001_0000);
				end
				default: begin
					write_reg(qwm_pkg::REG_THRUST_GAIN, $urandom);
					write_reg(qwm_pkg::REG_ROLL_PITCH_GAIN, $urandom_range(0, 1) ? $urandom
						: $urandom_range(0, 1 << 24));
					write_reg(qwm_pkg::REG_YAW_GAIN, $urandom);
					write_reg(qwm_pkg::REG_MIN_SPEED, $urandom_range(0, 2000));
					write_reg(qwm_pkg::REG_MAX_SPEED, $urandom_range(1, 65535));
					write_reg(qwm_pkg::REG_COMMAND_SCALE, $urandom_range(0, 1) ? $urandom
						: $urandom_range(0, 1 << 20));
				end
			endcase
			send_burst(50, 2);
			send_burst(30, 1);
			send_burst(20, 0);
			drain();
		end

		$display("covered %0d wrench words and %0d command words", words_in, words_out);
		$display("directed corners, ten register settings, bursty input and receiver stalls");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
